/* rtl/core/mbe_pkg.sv */
package mbe_pkg;

  localparam int PIX_W  = 10;
  localparam int ITER_W = 12;
  localparam int GRAY_W = 8;
  localparam int SIZE_W = 13;
  localparam int Z_W    = 32;
  localparam int P_W    = 64;
  localparam int FRAC_W = 28;
  localparam int Q_W    = FRAC_W + 1;
  localparam int REM_W  = ITER_W + GRAY_W;
  localparam int STEP_W = $clog2(GRAY_W);

  // coordinate mapping by reciprocal multiplication
  localparam int RCP_W    = 36;
  localparam int RCP_H    = RCP_W / 2;
  localparam int X_W      = 2 * SIZE_W;
  localparam int BASE_P_W = SIZE_W + Q_W;
  localparam int ACC_W    = X_W + RCP_H;
  localparam int HI_W     = ACC_W + 1;

  localparam int DEF_WIDTH  = 1024;
  localparam int DEF_HEIGHT = 1024;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(550);

  // |z|^2 bound of 4 in Q8.56
  localparam logic [P_W-1:0] ESC_BOUND = P_W'(1) << (2 * FRAC_W + 2);

  localparam int MAP_STEPS = 3;

  localparam logic [STEP_W-1:0] MAP_LAST  = STEP_W'(MAP_STEPS - 1);
  localparam logic [STEP_W-1:0] GRAY_LAST = STEP_W'(GRAY_W - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAP  = 7'b0000010,
    S_CFIX = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_GRAY = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic map_step;
    logic c_fix;
    logic mul;
    logic upd;
    logic gray_load;
    logic gray_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escape;
  } status_t;

endpackage

/* rtl/core/mbe_coord_div.sv */
module mbe_coord_div #(
  parameter int SIZE = mbe_pkg::DEF_WIDTH
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           step,
  input  logic [mbe_pkg::PIX_W-1:0]      pix,
  output logic signed [mbe_pkg::Z_W-1:0] c
);
  import mbe_pkg::*;

  localparam logic [SIZE_W-1:0] SIZE_V = SIZE_W'(SIZE);
  localparam logic [Z_W-1:0]    C_SAT  = Z_W'(1) << Q_W;
  // 2^29 = Q0 * SIZE + R0; reciprocal of SIZE scaled by 2^36, rounded up
  localparam logic [Q_W-1:0]    Q0_V   = Q_W'((longint'(1) << Q_W) / longint'(SIZE));
  localparam logic [SIZE_W-1:0] R0_V   = SIZE_W'((longint'(1) << Q_W) % longint'(SIZE));
  localparam logic [RCP_W-1:0]  RCP_V  =
    RCP_W'(((longint'(1) << RCP_W) + longint'(SIZE) - 1) / longint'(SIZE));

  logic signed [SIZE_W:0] n;
  logic [SIZE_W:0]        n_abs;
  logic [SIZE_W-1:0]      mag;
  logic [X_W-1:0]         x_prod;
  logic [BASE_P_W-1:0]    base_prod;
  logic [ACC_W-1:0]       lo_prod;
  logic [ACC_W-1:0]       hi_prod;
  logic [HI_W-1:0]        hi_sum;
  logic [Z_W-1:0]         q_sum;
  logic [Z_W-1:0]         c_mag;

  logic [SIZE_W-1:0] mag_r;
  logic [X_W-1:0]    x_r;
  logic [Q_W:0]      base_r;
  logic [ACC_W-1:0]  acc_r;
  logic [HI_W-1:0]   hi_r;
  logic              neg_r;
  logic              sat_r;

  // 2*pix - size, then its magnitude
  assign n      = $signed({3'b000, pix, 1'b0}) - $signed({1'b0, SIZE_V});
  assign n_abs  = n[SIZE_W] ? (~n + 1'b1) : n;
  assign mag    = n_abs[SIZE_W-1:0];

  // mag*2^29/size = mag*Q0 + mag*R0/size; the last term by reciprocal,
  // low half of the reciprocal one step ahead of the high half
  assign x_prod    = X_W'(mag_r) * X_W'(R0_V);
  assign base_prod = BASE_P_W'(mag_r) * BASE_P_W'(Q0_V);
  assign lo_prod   = ACC_W'(x_r) * ACC_W'(RCP_V[RCP_H-1:0]);
  assign hi_prod   = ACC_W'(x_r) * ACC_W'(RCP_V[RCP_W-1:RCP_H]);
  assign hi_sum    = HI_W'(hi_prod) + HI_W'(acc_r[ACC_W-1:RCP_H]);
  assign q_sum     = Z_W'(base_r) + Z_W'(hi_r[HI_W-1:RCP_H]);

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= mag;
      neg_r <= n[SIZE_W];
      sat_r <= mag >= SIZE_V;
    end else if (step) begin
      x_r    <= x_prod;
      base_r <= base_prod[Q_W:0];
      acc_r  <= lo_prod;
      hi_r   <= hi_sum;
    end
  end

  // clamp to +/-2 when the pixel lies at 0 or beyond the image
  assign c_mag = sat_r ? C_SAT : q_sum;
  assign c     = neg_r ? $signed(~c_mag + 1'b1) : $signed(c_mag);

endmodule

/* rtl/core/mbe_datapath.sv */
module mbe_datapath #(
  parameter int WIDTH  = mbe_pkg::DEF_WIDTH,
  parameter int HEIGHT = mbe_pkg::DEF_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mbe_pkg::ITER_W-1:0]   cfg_wr_data,
  input  logic [mbe_pkg::PIX_W-1:0]    in_pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]    in_pixel_y,
  input  mbe_pkg::cmd_t                cmd,
  output mbe_pkg::status_t             status,
  output logic [mbe_pkg::GRAY_W-1:0]   out_gray_level,
  output logic [mbe_pkg::ITER_W-1:0]   out_iterations,
  output logic                         out_inside_set
);
  import mbe_pkg::*;

  logic [ITER_W-1:0]     max_iter_r;
  logic signed [Z_W-1:0] cr_r, ci_r, zr_r, zi_r;
  logic signed [Z_W-1:0] cr_lane, ci_lane;
  logic [ITER_W-1:0]     iter_r;
  logic signed [P_W-1:0] rr_r, ii_r, ri_r;
  logic [REM_W-1:0]      rem_r, div_r;
  logic [GRAY_W-1:0]     gq_r;
  logic [GRAY_W-1:0]     gray_r;
  logic [ITER_W-1:0]     iter_out_r;
  logic                  inside_r;

  logic [P_W-1:0]        mag_sum;
  logic signed [P_W-1:0] diff;
  logic signed [P_W-1:0] zr_sh, zi_sh;
  logic [REM_W-1:0]      scaled;
  logic                  gray_ge;

  mbe_coord_div #(.SIZE(WIDTH)) u_div_re (
    .clk  (clk),
    .load (cmd.load),
    .step (cmd.map_step),
    .pix  (in_pixel_x),
    .c    (cr_lane)
  );

  mbe_coord_div #(.SIZE(HEIGHT)) u_div_im (
    .clk  (clk),
    .load (cmd.load),
    .step (cmd.map_step),
    .pix  (in_pixel_y),
    .c    (ci_lane)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
    end else if (cfg_wr_en) begin
      max_iter_r <= cfg_wr_data;
    end
  end

  assign mag_sum = rr_r + ii_r;
  assign diff    = rr_r - ii_r;
  assign zr_sh   = diff >>> FRAC_W;
  assign zi_sh   = ri_r >>> (FRAC_W - 1);

  assign status.at_limit = iter_r >= max_iter_r;
  assign status.escape   = mag_sum >= ESC_BOUND;

  // iter * 255 without a multiplier
  assign scaled  = {iter_r, {GRAY_W{1'b0}}} - REM_W'(iter_r);
  assign gray_ge = rem_r >= div_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr_r   <= '0;
      zi_r   <= '0;
      iter_r <= '0;
    end else if (cmd.upd) begin
      zr_r   <= $signed(zr_sh[Z_W-1:0]) + cr_r;
      zi_r   <= $signed(zi_sh[Z_W-1:0]) + ci_r;
      iter_r <= iter_r + 1'b1;
    end
    if (cmd.c_fix) begin
      cr_r <= cr_lane;
      ci_r <= ci_lane;
    end
    if (cmd.mul) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    // restoring division, one quotient bit a cycle, MSB first
    if (cmd.gray_load) begin
      rem_r <= scaled;
      div_r <= REM_W'(max_iter_r) << (GRAY_W - 1);
      gq_r  <= '0;
    end else if (cmd.gray_step) begin
      rem_r <= gray_ge ? (rem_r - div_r) : rem_r;
      div_r <= div_r >> 1;
      gq_r  <= {gq_r[GRAY_W-2:0], gray_ge};
    end
    if (cmd.out_load) begin
      gray_r     <= status.at_limit ? '0 : gq_r;
      iter_out_r <= iter_r;
      inside_r   <= status.at_limit;
    end
  end

  assign out_gray_level = gray_r;
  assign out_iterations = iter_out_r;
  assign out_inside_set = inside_r;

endmodule

/* rtl/core/mbe_ctrl.sv */
module mbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  input  mbe_pkg::status_t  status,
  output mbe_pkg::cmd_t     cmd
);
  import mbe_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_step = 1'b1;
        if (step_r == MAP_LAST) begin
          state_nxt = S_CFIX;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_CFIX: begin
        cmd.c_fix = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (status.at_limit) begin
          cmd.gray_load = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_GRAY;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (status.escape) begin
          cmd.gray_load = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_GRAY;
        end else begin
          cmd.upd   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_GRAY: begin
        cmd.gray_step = 1'b1;
        if (step_r == GRAY_LAST) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/mandelbrot_escape_time.sv */
// Mandelbrot escape-time evaluator, one pixel at a time.
// Input channel: in_valid / in_stall with in_pixel_x, in_pixel_y. The pixel
// maps to c in [-2, 2] x [-2, 2] of an image of WIDTH x HEIGHT pixels.
// Result channel: out_valid / out_stall with out_gray_level, out_iterations
// and out_inside_set. Each item yields exactly one result.
// cfg_wr_en / cfg_wr_data set the iteration limit (550 after reset); write
// it only while no item is in flight.
// Sequence: mapping c uses reciprocal multiplication by the image size,
// then each iteration of z = z*z + c forms three parallel 32x32 products
// and then does the escape test and update, then a restoring division
// gives the gray level. The next item is taken in the cycle after the
// result is loaded, so the iteration loop sets the rate, one item at a
// time.
// A finished result sits in an output register, so the next item is taken
// while it waits. If the receiver stalls and a second result is ready, the
// controller holds that result and accepts no further item until the output
// register frees.
// Reset (rst_n low, synchronous) empties the block and restores the limit.
module mandelbrot_escape_time #(
  parameter int WIDTH  = mbe_pkg::DEF_WIDTH,
  parameter int HEIGHT = mbe_pkg::DEF_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mbe_pkg::PIX_W-1:0]    in_pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]    in_pixel_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mbe_pkg::GRAY_W-1:0]   out_gray_level,
  output logic [mbe_pkg::ITER_W-1:0]   out_iterations,
  output logic                         out_inside_set,
  input  logic                         cfg_wr_en,
  input  logic [mbe_pkg::ITER_W-1:0]   cfg_wr_data
);
  import mbe_pkg::*;

  cmd_t    cmd;
  status_t status;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  mbe_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .cmd            (cmd),
    .status         (status),
    .out_gray_level (out_gray_level),
    .out_iterations (out_iterations),
    .out_inside_set (out_inside_set)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while a previous one still in work");

  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_set) |-> (out_gray_level == '0))
    else $error("pixel inside the set carries a non-zero gray level");

  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_inside_set) |-> (out_iterations != '0))
    else $error("escape reported before any iteration");

  a_escape_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_inside_set) |-> (out_gray_level != '1))
    else $error("escaped pixel reached full gray");

endmodule
